// File: rtl/sgc_pkg.sv
// Shared types and constants for the Sobol Gray-code point generator.
// No dependencies; imported by the top level, sgc_seq and sgc_rsp_fifo.
package sgc_pkg;

   localparam int CMD_W     = 3;
   localparam int DIM_W     = 4;
   localparam int BIDX_W    = 5;
   localparam int FRAC_W    = 30;
   localparam int DIMS_W    = 5;
   localparam int OUT_LIMIT = 16;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   localparam logic REG_DIMENSIONS = 1'b0;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_DIR   = 3'd0,
      CMD_LOAD_QUASI = 3'd1,
      CMD_SET_COUNT  = 3'd2,
      CMD_DRAW       = 3'd3,
      CMD_SKIP       = 3'd4
   } cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [DIM_W-1:0]  dim_index;
      logic [BIDX_W-1:0] bit_index;
      logic [FRAC_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [DIM_W-1:0]  out_dim;
      logic [FRAC_W-1:0] sample;
      logic              last;
      logic              exhausted;
   } rsp_type;

endpackage

// File: rtl/sobol_gray_code_generator.sv
// Top level of the Sobol Gray-code point generator: APB register, memories, queue.
// Depends on sgc_pkg, sgc_mem, sgc_rsp_fifo and sgc_seq.
//
// Usage:
//  - req channel (valid/ready) carries commands: load direction number, load quasi
//    word, set point counter, draw point, skip point.
//  - A draw finds the lowest zero bit of the counter four bits per cycle, then
//    walks the active dimensions one per cycle while the result queue has room,
//    reading quasi word and direction number from their RAMs, XORing and
//    writing back. Each coordinate goes out on rsp as one transaction, last
//    flagged on the final one. A skip is the same with no output.
//  - A full counter gives one exhausted transaction and leaves all state alone.
//  - rsp sits behind a two-entry queue; a stalled receiver pauses the walk,
//    nothing is dropped. New commands are taken while results are queued.
//  - APB register 0 (dimensions) resets to 1. Reset clears the counter and
//    control state; direction and quasi RAMs are undefined until loaded.
module sobol_gray_code_generator #(
   parameter int DIM_MAX = 16,
   parameter int BITS    = 30
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [sgc_pkg::CMD_W-1:0]    req_command,
   input  logic [sgc_pkg::DIM_W-1:0]    req_dim_index,
   input  logic [sgc_pkg::BIDX_W-1:0]   req_bit_index,
   input  logic [sgc_pkg::FRAC_W-1:0]   req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [sgc_pkg::DIM_W-1:0]    rsp_out_dim,
   output logic [sgc_pkg::FRAC_W-1:0]   rsp_sample,
   output logic                         rsp_last,
   output logic                         rsp_exhausted,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [sgc_pkg::CSR_AW-1:0]   paddr,
   input  logic [sgc_pkg::CSR_DW-1:0]   pwdata,
   output logic [sgc_pkg::CSR_DW-1:0]   prdata,
   output logic                         pready
);
   import sgc_pkg::*;

   localparam int DW = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
   localparam int BW = $clog2(BITS);

   logic [DIMS_W-1:0] dims_ff;
   req_type           req;
   rsp_type           push_data;
   rsp_type           rsp_data;
   logic              push;
   logic              fifo_pop;
   logic [1:0]        fifo_count;

   logic              dir_we;
   logic [DW+BW-1:0]  dir_waddr;
   logic [BITS-1:0]   dir_wdata;
   logic [DW+BW-1:0]  dir_raddr;
   logic [BITS-1:0]   dir_rdata;
   logic              quasi_we;
   logic [DW-1:0]     quasi_waddr;
   logic [BITS-1:0]   quasi_wdata;
   logic [DW-1:0]     quasi_raddr;
   logic [BITS-1:0]   quasi_rdata;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_DIMENSIONS) ? CSR_DW'(dims_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= DIMS_W'(1);
      end else if (psel && penable && pwrite && pready && paddr[2] == REG_DIMENSIONS) begin
         dims_ff <= pwdata[DIMS_W-1:0];
      end
   end

   assign req.command   = req_command;
   assign req.dim_index = req_dim_index;
   assign req.bit_index = req_bit_index;
   assign req.value     = req_value;

   sgc_mem #(.WIDTH(BITS), .AW(DW+BW)) u_dir_mem (
      .clock (clock),
      .we    (dir_we),
      .waddr (dir_waddr),
      .wdata (dir_wdata),
      .raddr (dir_raddr),
      .rdata (dir_rdata)
   );

   sgc_mem #(.WIDTH(BITS), .AW(DW)) u_quasi_mem (
      .clock (clock),
      .we    (quasi_we),
      .waddr (quasi_waddr),
      .wdata (quasi_wdata),
      .raddr (quasi_raddr),
      .rdata (quasi_rdata)
   );

   sgc_seq #(.DIM_MAX(DIM_MAX), .BITS(BITS), .DW(DW), .BW(BW)) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req         (req),
      .dims        (dims_ff),
      .fifo_count  (fifo_count),
      .fifo_pop    (fifo_pop),
      .push        (push),
      .push_data   (push_data),
      .dir_we      (dir_we),
      .dir_waddr   (dir_waddr),
      .dir_wdata   (dir_wdata),
      .dir_raddr   (dir_raddr),
      .dir_rdata   (dir_rdata),
      .quasi_we    (quasi_we),
      .quasi_waddr (quasi_waddr),
      .quasi_wdata (quasi_wdata),
      .quasi_raddr (quasi_raddr),
      .quasi_rdata (quasi_rdata)
   );

   sgc_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .count     (fifo_count),
      .pop       (fifo_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_out_dim   = rsp_data.out_dim;
   assign rsp_sample    = rsp_data.sample;
   assign rsp_last      = rsp_data.last;
   assign rsp_exhausted = rsp_data.exhausted;

endmodule

// File: rtl/sgc_mem.sv
// Simple dual-port synchronous RAM: one write port, one read port, registered read.
// No dependencies; holds the direction table and the quasi words.
module sgc_mem #(
   parameter int WIDTH = 30,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [2**AW];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/sgc_rsp_fifo.sv
// Two-entry result queue between the sequencer and the rsp channel.
// Depends on sgc_pkg for the result transaction type.
module sgc_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sgc_pkg::rsp_type  push_data,
   output logic [1:0]        count,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sgc_pkg::rsp_type  rsp_data
);
   import sgc_pkg::*;

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != 2'd2 || pop))
      else $error("result queue overflow");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0) |-> !pop)
      else $error("result queue underflow");

endmodule

// File: rtl/sgc_seq.sv
// Command sequencer: loads, counter, lowest-zero-bit scan and per-dimension XOR update.
// Depends on sgc_pkg; drives both memories and the result queue.
module sgc_seq #(
   parameter int DIM_MAX = 16,
   parameter int BITS    = 30,
   parameter int DW      = 4,
   parameter int BW      = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  sgc_pkg::req_type           req,
   input  logic [sgc_pkg::DIMS_W-1:0] dims,
   input  logic [1:0]                 fifo_count,
   input  logic                       fifo_pop,
   output logic                       push,
   output sgc_pkg::rsp_type           push_data,
   output logic                       dir_we,
   output logic [DW+BW-1:0]           dir_waddr,
   output logic [BITS-1:0]            dir_wdata,
   output logic [DW+BW-1:0]           dir_raddr,
   input  logic [BITS-1:0]            dir_rdata,
   output logic                       quasi_we,
   output logic [DW-1:0]              quasi_waddr,
   output logic [BITS-1:0]            quasi_wdata,
   output logic [DW-1:0]              quasi_raddr,
   input  logic [BITS-1:0]            quasi_rdata
);
   import sgc_pkg::*;

   localparam int DimLimit = (DIM_MAX < OUT_LIMIT) ? DIM_MAX : OUT_LIMIT;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RUN,
      ST_EXH
   } state_type;

   state_type        state_ff;
   logic [BITS-1:0]  count_ff;
   logic [BITS-1:0]  scan_ff;
   logic [BW-1:0]    lvl_ff;
   logic [DIM_W-1:0] j_ff;
   logic             draw_ff;
   logic             b_valid_ff;
   logic             b_draw_ff;
   logic [DIM_W-1:0] b_j_ff;
   logic             b_last_ff;

   cmd_type          cmd;
   logic             accept;
   logic             dim_ok;
   logic             load_quasi;
   logic [DIMS_W-1:0] n_eff;
   logic [DIM_W-1:0] last_idx;
   logic [BITS-1:0]  new_word;
   logic [FRAC_W-1:0] frac;
   logic [2:0]       occ;
   logic             issue;
   logic             exh_push;
   logic             nib_zero;
   logic [2:0]       tz;

   always_comb begin
      if (dims == '0) begin
         n_eff = DIMS_W'(1);
      end else if (32'(dims) > DimLimit) begin
         n_eff = DIMS_W'(DimLimit);
      end else begin
         n_eff = dims;
      end
   end
   assign last_idx = DIM_W'(n_eff - DIMS_W'(1));

   assign cmd        = cmd_type'(req.command);
   assign req_ready  = (state_ff == ST_IDLE) && !b_valid_ff;
   assign accept     = req_valid && req_ready;
   assign dim_ok     = 32'(req.dim_index) < DIM_MAX;
   assign load_quasi = accept && (cmd == CMD_LOAD_QUASI) && dim_ok;

   assign dir_we    = accept && (cmd == CMD_LOAD_DIR) && dim_ok && (32'(req.bit_index) < BITS);
   assign dir_waddr = {DW'(req.dim_index), BW'(req.bit_index)};
   assign dir_wdata = BITS'(req.value);
   assign dir_raddr = {DW'(j_ff), lvl_ff};

   assign new_word    = quasi_rdata ^ dir_rdata;
   assign quasi_we    = b_valid_ff || load_quasi;
   assign quasi_waddr = b_valid_ff ? DW'(b_j_ff) : DW'(req.dim_index);
   assign quasi_wdata = b_valid_ff ? new_word : BITS'(req.value);
   assign quasi_raddr = DW'(j_ff);

   generate
      if (BITS >= FRAC_W) begin : g_frac_trunc
         assign frac = new_word[BITS-1 -: FRAC_W];
      end else begin : g_frac_pad
         assign frac = {new_word, {(FRAC_W-BITS){1'b0}}};
      end
   endgenerate

   // results in queue after this cycle, counting the one in the read stage
   assign occ   = 3'({1'b0, fifo_count}) + 3'(b_valid_ff && b_draw_ff) - 3'(fifo_pop);
   assign issue = (state_ff == ST_RUN) && (!draw_ff || occ < 3'd2);

   assign exh_push = (state_ff == ST_EXH) && (fifo_count != 2'd2 || fifo_pop);
   assign push     = exh_push || (b_valid_ff && b_draw_ff);

   always_comb begin
      if (exh_push) begin
         push_data.out_dim   = '0;
         push_data.sample    = '0;
         push_data.last      = 1'b1;
         push_data.exhausted = 1'b1;
      end else begin
         push_data.out_dim   = b_j_ff;
         push_data.sample    = frac;
         push_data.last      = b_last_ff;
         push_data.exhausted = 1'b0;
      end
   end

   assign nib_zero = (scan_ff[3:0] != 4'hF);
   always_comb begin
      priority if (!scan_ff[0]) begin
         tz = 3'd0;
      end else if (!scan_ff[1]) begin
         tz = 3'd1;
      end else if (!scan_ff[2]) begin
         tz = 3'd2;
      end else begin
         tz = 3'd3;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= issue;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (cmd == CMD_SET_COUNT) begin
                     count_ff <= BITS'(req.value);
                  end else if (cmd == CMD_DRAW || cmd == CMD_SKIP) begin
                     if (count_ff == {BITS{1'b1}}) begin
                        state_ff <= ST_EXH;
                     end else begin
                        state_ff <= ST_SCAN;
                     end
                  end
               end
            end
            ST_SCAN: begin
               if (nib_zero) begin
                  count_ff <= count_ff + BITS'(1);
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (issue && j_ff == last_idx) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_EXH: begin
               if (exh_push) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end

      b_draw_ff <= draw_ff;
      b_j_ff    <= j_ff;
      b_last_ff <= (j_ff == last_idx);
      if (state_ff == ST_IDLE && accept) begin
         draw_ff <= (cmd == CMD_DRAW);
         scan_ff <= count_ff;
         lvl_ff  <= '0;
      end
      if (state_ff == ST_SCAN) begin
         j_ff <= '0;
         if (nib_zero) begin
            lvl_ff <= lvl_ff + BW'(tz);
         end else begin
            scan_ff <= scan_ff >> 4;
            lvl_ff  <= lvl_ff + BW'(4);
         end
      end
      if (issue) begin
         j_ff <= j_ff + DIM_W'(1);
      end
   end

   a_scan_has_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_ff != {BITS{1'b1}}))
      else $error("bit scan started on a full counter");

   a_level_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (32'(lvl_ff) < BITS))
      else $error("direction level out of range");

   a_stage_dim: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (b_j_ff <= last_idx))
      else $error("update past last active dimension");

   a_no_load_during_update: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> !accept)
      else $error("transaction accepted during quasi update");

endmodule

// File: bench/sobol_gray_code_generator_tb.sv
// Self-checking bench for the Sobol Gray-code point generator: directed corners and
// randomized command streams under sender/receiver backpressure, checked per coordinate.
// Depends on sgc_pkg and the sobol_gray_code_generator RTL.
module sobol_gray_code_generator_tb;
   import sgc_pkg::*;

   localparam int DIM_MAX      = 16;
   localparam int BITS         = 30;
   localparam int RESET_CYCLES = 5;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int RAND_PHASES  = 4;
   localparam int PHASE_ITEMS  = 62;
   // random counters stay well below 2**PRELOAD_LEVELS - 1, so draws use loaded levels only
   localparam int PRELOAD_LEVELS = 10;
   localparam int RUN_MAX        = 7;

   localparam logic [CMD_W-1:0]  CMD_RSVD_FIRST = 3'd5;
   localparam logic [CMD_W-1:0]  CMD_RSVD_LAST  = 3'd7;
   localparam logic [CSR_AW-1:0] DIMS_ADDR      = {REG_DIMENSIONS, 2'b00};
   localparam logic [FRAC_W-1:0] FULL_WORD      = '1;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CMD_W-1:0]    req_command = '0;
   logic [DIM_W-1:0]    req_dim_index = '0;
   logic [BIDX_W-1:0]   req_bit_index = '0;
   logic [FRAC_W-1:0]   req_value = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [DIM_W-1:0]    rsp_out_dim;
   logic [FRAC_W-1:0]   rsp_sample;
   logic                rsp_last;
   logic                rsp_exhausted;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [CSR_AW-1:0]   paddr = '0;
   logic [CSR_DW-1:0]   pwdata = '0;
   logic [CSR_DW-1:0]   prdata;
   logic                pready;

   // predictor state
   logic [FRAC_W-1:0]   dir_numbers [DIM_MAX][BITS];
   logic [FRAC_W-1:0]   quasi_state [DIM_MAX];
   logic [FRAC_W-1:0]   point_counter;
   logic [DIMS_W-1:0]   dims_setting;
   rsp_type             expected_coords[$];

   int                  errors = 0;
   int                  cycles = 0;
   int                  send_idle_pct = 0;
   int                  stall_pct = 0;

   sobol_gray_code_generator #(
      .DIM_MAX(DIM_MAX),
      .BITS   (BITS)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_dim_index(req_dim_index),
      .req_bit_index(req_bit_index),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_dim  (rsp_out_dim),
      .rsp_sample   (rsp_sample),
      .rsp_last     (rsp_last),
      .rsp_exhausted(rsp_exhausted),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[sobol_gray_code_generator] ERROR");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99, 0) >= stall_pct);
   end

   function automatic int active_dims();
      if (dims_setting == 0) return 1;
      if (dims_setting > DIM_MAX) return DIM_MAX;
      return int'(dims_setting);
   endfunction

   task automatic predict_coords(input logic [CMD_W-1:0] cmd, input logic [DIM_W-1:0] di,
                                 input logic [BIDX_W-1:0] bi, input logic [FRAC_W-1:0] val);
      rsp_type coord;
      int      low;
      int      n;
      case (cmd)
         CMD_LOAD_DIR: begin
            if (bi < BITS) dir_numbers[di][bi] = val;
         end
         CMD_LOAD_QUASI: begin
            quasi_state[di] = val;
         end
         CMD_SET_COUNT: begin
            point_counter = val;
         end
         CMD_DRAW, CMD_SKIP: begin
            if (point_counter == FULL_WORD) begin
               coord = '{out_dim: '0, sample: '0, last: 1'b1, exhausted: 1'b1};
               expected_coords.push_back(coord);
            end else begin
               low = 0;
               while (point_counter[low]) low++;
               n = active_dims();
               for (int j = 0; j < n; j++) quasi_state[j] ^= dir_numbers[j][low];
               point_counter = point_counter + 1'b1;
               if (cmd == CMD_DRAW) begin
                  for (int j = 0; j < n; j++) begin
                     coord.out_dim   = DIM_W'(j);
                     coord.sample    = quasi_state[j];
                     coord.last      = (j == n - 1);
                     coord.exhausted = 1'b0;
                     expected_coords.push_back(coord);
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         predict_coords(req_command, req_dim_index, req_bit_index, req_value);
   end

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{out_dim: rsp_out_dim, sample: rsp_sample, last: rsp_last,
                 exhausted: rsp_exhausted};
         if (expected_coords.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction dim=%0d sample=%h last=%b exh=%b",
                     $time, got.out_dim, got.sample, got.last, got.exhausted);
         end else begin
            want = expected_coords.pop_front();
            if (got !== want) begin
               errors++;
               $display("%0t: mismatch exp dim=%0d sample=%h last=%b exh=%b",
                        $time, want.out_dim, want.sample, want.last, want.exhausted);
               $display("%0t:          act dim=%0d sample=%h last=%b exh=%b",
                        $time, got.out_dim, got.sample, got.last, got.exhausted);
            end
         end
      end
   end

   // called at a falling edge, returns at a falling edge; valid stays up for back-to-back
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [DIM_W-1:0] di,
                            input logic [BIDX_W-1:0] bi, input logic [FRAC_W-1:0] val);
      bit taken;
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_command   = cmd;
      req_dim_index = di;
      req_bit_index = bi;
      req_value     = val;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = req_ready;
      end
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid = 1'b0;
      while (expected_coords.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_dimensions(input logic [DIMS_W-1:0] dims);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = DIMS_ADDR;
      pwdata  = CSR_DW'(dims);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      dims_setting = dims;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // counter value with k trailing ones, so the draw uses bit k (k == BITS exhausts)
   function automatic logic [FRAC_W-1:0] counter_with_run(input int k);
      logic [FRAC_W-1:0] v;
      v = FRAC_W'($urandom_range(255, 0));
      if (k >= BITS) return FULL_WORD;
      v = v | FRAC_W'((64'd1 << k) - 1);
      v[k] = 1'b0;
      return v;
   endfunction

   task automatic test_preload();
      for (int d = 0; d < DIM_MAX; d++) begin
         for (int b = 0; b < PRELOAD_LEVELS; b++)
            send_item(CMD_LOAD_DIR, DIM_W'(d), BIDX_W'(b), FRAC_W'($urandom));
         send_item(CMD_LOAD_QUASI, DIM_W'(d), BIDX_W'($urandom), FRAC_W'($urandom));
      end
      // top level of dimension 0, used by the long-run draw among the corners
      send_item(CMD_LOAD_DIR, '0, BIDX_W'(BITS - 1), FRAC_W'($urandom));
   endtask

   task automatic test_corner_cases();
      send_item(CMD_SET_COUNT, '0, '0, '0);
      send_item(CMD_DRAW, '1, '1, FULL_WORD);
      send_item(CMD_SKIP, '0, '0, '0);
      send_item(CMD_DRAW, '0, '0, '0);
      // out-of-range bit positions are ignored
      send_item(CMD_LOAD_DIR, '0, BIDX_W'(BITS), FULL_WORD);
      send_item(CMD_LOAD_DIR, '1, '1, FULL_WORD);
      send_item(CMD_LOAD_DIR, '0, '0, FULL_WORD);
      send_item(CMD_LOAD_DIR, '1, BIDX_W'(BITS - 1), FULL_WORD);
      send_item(CMD_LOAD_QUASI, '0, '0, FULL_WORD);
      send_item(CMD_LOAD_QUASI, '1, '1, '0);
      send_item(CMD_DRAW, '0, '0, '0);
      for (int c = CMD_RSVD_FIRST; c <= CMD_RSVD_LAST; c++)
         send_item(CMD_W'(c), '1, '1, FULL_WORD);
      send_item(CMD_SET_COUNT, '0, '0, FULL_WORD);
      send_item(CMD_DRAW, '0, '0, '0);
      send_item(CMD_SKIP, '0, '0, '0);
      send_item(CMD_SET_COUNT, '0, '0, counter_with_run(BITS - 1));
      send_item(CMD_DRAW, '0, '0, '0);
      send_item(CMD_SET_COUNT, '0, '0, FULL_WORD - 1'b1);
      send_item(CMD_DRAW, '0, '0, '0);
      send_item(CMD_DRAW, '0, '0, '0);
      send_item(CMD_SET_COUNT, '0, '0, '0);
   endtask

   task automatic test_dimension_limits();
      logic [DIMS_W-1:0] settings [4];
      settings = '{DIMS_W'(0), DIMS_W'(31), DIMS_W'(DIM_MAX), DIMS_W'(1)};
      foreach (settings[i]) begin
         wait_idle();
         write_dimensions(settings[i]);
         send_item(CMD_DRAW, '0, '0, '0);
         send_item(CMD_SKIP, '0, '0, '0);
         send_item(CMD_DRAW, '0, '0, '0);
      end
   endtask

   task automatic test_random_stream(input int items);
      int r;
      for (int i = 0; i < items; i++) begin
         r = $urandom_range(99, 0);
         if (r < 50)
            send_item(CMD_DRAW, DIM_W'($urandom), BIDX_W'($urandom), FRAC_W'($urandom));
         else if (r < 64)
            send_item(CMD_SKIP, DIM_W'($urandom), BIDX_W'($urandom), FRAC_W'($urandom));
         else if (r < 73)
            send_item(CMD_SET_COUNT, DIM_W'($urandom), BIDX_W'($urandom),
                      counter_with_run((r == 64) ? BITS : int'($urandom_range(RUN_MAX, 0))));
         else if (r < 84)
            send_item(CMD_LOAD_DIR, DIM_W'($urandom_range(DIM_MAX - 1, 0)),
                      BIDX_W'($urandom_range(31, 0)), FRAC_W'($urandom));
         else if (r < 93)
            send_item(CMD_LOAD_QUASI, DIM_W'($urandom_range(DIM_MAX - 1, 0)),
                      BIDX_W'($urandom), FRAC_W'($urandom));
         else
            send_item(CMD_W'($urandom_range(CMD_RSVD_LAST, CMD_RSVD_FIRST)),
                      DIM_W'($urandom), BIDX_W'($urandom), FRAC_W'($urandom));
      end
   endtask

   initial begin
      int send_pcts  [RAND_PHASES];
      int stall_pcts [RAND_PHASES];
      point_counter = '0;
      dims_setting  = DIMS_W'(1);
      send_pcts  = '{0, 52, 0, 29};
      stall_pcts = '{0, 0, 52, 29};
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_preload();
      test_corner_cases();
      stall_pct = 29;
      send_idle_pct = 29;
      test_dimension_limits();
      for (int p = 0; p < RAND_PHASES; p++) begin
         wait_idle();
         send_idle_pct = send_pcts[p];
         stall_pct     = stall_pcts[p];
         write_dimensions((p == 0) ? DIMS_W'(DIM_MAX) : DIMS_W'($urandom_range(DIM_MAX, 1)));
         test_random_stream(PHASE_ITEMS);
      end
      wait_idle();

      if (errors == 0 && expected_coords.size() == 0) begin
         $display("[sobol_gray_code_generator] OK");
      end else begin
         $display("[sobol_gray_code_generator] ERROR");
      end
      $finish;
   end

endmodule
